// File: rtl/qwt_pkg.sv
package qwt_pkg;

    // word buffer geometry
    localparam int WORD_DEPTH    = 32;
    localparam int AW            = $clog2(WORD_DEPTH);
    localparam int CNT_W         = $clog2(WORD_DEPTH + 1);
    localparam int CAPACITY_BITS = 12;

    // configuration port
    localparam int CFG_DW  = (CAPACITY_BITS > 8) ? CAPACITY_BITS : 8;
    localparam int LIMIT_W = 6;
    localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam logic [1:0] REG_SEPARATOR  = 2'd0;
    localparam logic [1:0] REG_WORD_LIMIT = 2'd1;
    localparam logic [1:0] REG_LINE_CAP   = 2'd2;

    localparam logic [7:0]               SEP_RESET = 8'd32;
    localparam logic [CAPACITY_BITS-1:0] CAP_RESET = CAPACITY_BITS'(255);

    // character codes
    localparam logic [7:0] QUOTE_DOUBLE = 8'd34;
    localparam logic [7:0] QUOTE_SINGLE = 8'd39;
    localparam logic [7:0] SPACE_CODE   = 8'd32;

    localparam logic MODE_CHAR  = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // buffer write from front to back
    typedef struct packed {
        logic          en;
        logic [AW:0]   addr;
        logic [7:0]    data;
    } wr_t;

    // one word to emit
    typedef struct packed {
        logic             bank;
        logic             start;
        logic [CNT_W-1:0] len;
    } cmd_t;

    // back is done with a buffer bank
    typedef struct packed {
        logic en;
        logic bank;
    } rel_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == SPACE_CODE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

endpackage

// File: rtl/qwt_front.sv
module qwt_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             mode,
    input  logic [7:0]                       char_in,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [qwt_pkg::CFG_DW-1:0]       cfg_data,
    output qwt_pkg::wr_t                     wr,
    output logic                             cmd_valid,
    input  logic                             cmd_ready,
    output qwt_pkg::cmd_t                    cmd,
    input  qwt_pkg::rel_t                    rel
);

    logic [7:0]                         sep_reg;
    logic [qwt_pkg::LIMIT_W-1:0]        limit_reg;
    logic [qwt_pkg::CAPACITY_BITS-1:0]  cap_reg;

    logic [qwt_pkg::CAPACITY_BITS-1:0]  acc_reg, acc_next;
    logic [qwt_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic [qwt_pkg::CNT_W-1:0]          solid_reg, solid_next;
    logic                               inq_reg, inq_next;
    logic                               kind_reg, kind_next;
    logic [1:0]                         seg_reg, seg_next;
    logic                               skip_reg, skip_next;
    logic                               bank_reg, bank_next;
    logic [1:0]                         busy_reg, busy_next;
    logic [7:0]                         first_reg, first_next;
    logic [7:0]                         last_reg, last_next;

    logic                               accept;
    logic                               push;
    logic                               do_store;
    logic                               do_clear;
    logic                               strip;
    logic [qwt_pkg::CNT_W-1:0]          len_s;
    logic [qwt_pkg::CNT_W-1:0]          len_f;
    logic [7:0]                         open_q;

    assign cfg_ready = 1'b1;
    assign in_ready  = !busy_reg[bank_reg] && cmd_ready;
    assign accept    = in_valid && in_ready;
    assign open_q    = kind_reg ? qwt_pkg::QUOTE_SINGLE : qwt_pkg::QUOTE_DOUBLE;

    // strip enclosing quotes, then apply the word limit
    assign strip = (seg_reg == 2'd1) && (solid_reg >= qwt_pkg::CNT_W'(2))
                && (first_reg == qwt_pkg::QUOTE_DOUBLE || first_reg == qwt_pkg::QUOTE_SINGLE)
                && (last_reg == first_reg);
    assign len_s = strip ? solid_reg - qwt_pkg::CNT_W'(2) : solid_reg;
    assign len_f = (limit_reg != '0
                 && qwt_pkg::CMP_W'(len_s) > qwt_pkg::CMP_W'(limit_reg))
                 ? qwt_pkg::CNT_W'(limit_reg) : len_s;

    assign cmd.bank  = bank_reg;
    assign cmd.start = strip;
    assign cmd.len   = len_f;
    assign cmd_valid = push;

    always_comb
    begin
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        solid_next = solid_reg;
        inq_next   = inq_reg;
        kind_next  = kind_reg;
        seg_next   = seg_reg;
        skip_next  = skip_reg;
        bank_next  = bank_reg;
        first_next = first_reg;
        last_next  = last_reg;
        push       = 1'b0;
        do_store   = 1'b0;
        do_clear   = 1'b0;
        wr         = '0;

        if (accept)
        begin
            if (mode == qwt_pkg::MODE_FLUSH)
            begin
                push     = !skip_reg;
                do_clear = 1'b1;
                acc_next = '0;
            end
            else if (acc_reg < cap_reg)
            begin
                acc_next = acc_reg + 1'b1;
                if (!(skip_reg && qwt_pkg::is_space(char_in)))
                begin
                    skip_next = 1'b0;
                    if (inq_reg)
                    begin
                        if (char_in == open_q)
                        begin
                            inq_next = 1'b0;
                        end
                        do_store = 1'b1;
                    end
                    else if (char_in == sep_reg)
                    begin
                        push     = 1'b1;
                        do_clear = 1'b1;
                    end
                    else
                    begin
                        if (char_in == qwt_pkg::QUOTE_DOUBLE
                            || char_in == qwt_pkg::QUOTE_SINGLE)
                        begin
                            inq_next  = 1'b1;
                            kind_next = (char_in == qwt_pkg::QUOTE_SINGLE);
                            if (seg_reg != 2'd2)
                            begin
                                seg_next = seg_reg + 2'd1;
                            end
                        end
                        do_store = 1'b1;
                    end
                end
            end
        end

        // characters past the buffer depth still steer quote tracking
        if (do_store && cnt_reg < qwt_pkg::CNT_W'(qwt_pkg::WORD_DEPTH))
        begin
            wr.en   = 1'b1;
            wr.addr = {bank_reg, cnt_reg[qwt_pkg::AW-1:0]};
            wr.data = char_in;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == '0)
            begin
                first_next = char_in;
            end
            if (!qwt_pkg::is_space(char_in))
            begin
                solid_next = cnt_reg + 1'b1;
                last_next  = char_in;
            end
        end

        if (do_clear)
        begin
            cnt_next   = '0;
            solid_next = '0;
            inq_next   = 1'b0;
            kind_next  = 1'b0;
            seg_next   = 2'd0;
            skip_next  = 1'b1;
        end

        if (push)
        begin
            bank_next = ~bank_reg;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (rel.en)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (push)
        begin
            busy_next[bank_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg   <= qwt_pkg::SEP_RESET;
            limit_reg <= '0;
            cap_reg   <= qwt_pkg::CAP_RESET;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            solid_reg <= '0;
            inq_reg   <= 1'b0;
            kind_reg  <= 1'b0;
            seg_reg   <= 2'd0;
            skip_reg  <= 1'b1;
            bank_reg  <= 1'b0;
            busy_reg  <= 2'b00;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    qwt_pkg::REG_SEPARATOR:  sep_reg   <= cfg_data[7:0];
                    qwt_pkg::REG_WORD_LIMIT: limit_reg <= cfg_data[qwt_pkg::LIMIT_W-1:0];
                    qwt_pkg::REG_LINE_CAP:   cap_reg   <= cfg_data[qwt_pkg::CAPACITY_BITS-1:0];
                    default: ;
                endcase
            end
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            solid_reg <= solid_next;
            inq_reg   <= inq_next;
            kind_reg  <= kind_next;
            seg_reg   <= seg_next;
            skip_reg  <= skip_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        last_reg  <= last_next;
    end

`ifndef SYNTHESIS
    a_push_free_bank: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !busy_reg[bank_reg])
        else $error("word pushed into a bank still being emitted");

    a_release_held: assert property (@(posedge clk) disable iff (!rst_n)
        rel.en |-> busy_reg[rel.bank])
        else $error("release of a bank that was not held");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= qwt_pkg::CNT_W'(qwt_pkg::WORD_DEPTH) && solid_reg <= cnt_reg)
        else $error("word count out of range");
`endif

endmodule

// File: rtl/qwt_queue.sv
module qwt_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  qwt_pkg::cmd_t  in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output qwt_pkg::cmd_t  out_cmd
);

    qwt_pkg::cmd_t ent_reg [2];
    logic          wp_reg, wp_next;
    logic          rp_reg, rp_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push;
    logic          pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = ent_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= in_cmd;
        end
    end

endmodule

// File: rtl/qwt_back.sv
module qwt_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  qwt_pkg::wr_t   wr,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  qwt_pkg::cmd_t  cmd,
    output qwt_pkg::rel_t  rel,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     word_char,
    output logic           char_valid,
    output logic           word_end
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    // two banks of the word buffer, one per word in flight
    logic [7:0] mem [2 * qwt_pkg::WORD_DEPTH];

    logic [1:0]                state_reg, state_next;
    logic                      bank_reg, bank_next;
    logic                      start_reg, start_next;
    logic [qwt_pkg::CNT_W-1:0] len_reg, len_next;
    logic [qwt_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic                      empty_reg, empty_next;
    logic                      end_reg, end_next;
    logic [7:0]                rdata_reg;
    logic                      rd_en;
    logic [qwt_pkg::AW:0]      rd_addr;

    assign rd_addr = {bank_reg,
                      qwt_pkg::AW'(start_reg) + idx_reg[qwt_pkg::AW-1:0]};

    assign cmd_ready  = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign word_char  = empty_reg ? 8'd0 : rdata_reg;
    assign char_valid = !empty_reg;
    assign word_end   = end_reg;

    always_comb
    begin
        state_next = state_reg;
        bank_next  = bank_reg;
        start_next = start_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        empty_next = empty_reg;
        end_next   = end_reg;
        rd_en      = 1'b0;
        rel        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    bank_next  = cmd.bank;
                    start_next = cmd.start;
                    len_next   = cmd.len;
                    idx_next   = '0;
                    if (cmd.len == '0)
                    begin
                        empty_next = 1'b1;
                        end_next   = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                rd_en      = 1'b1;
                empty_next = 1'b0;
                end_next   = ((idx_reg + 1'b1) == len_reg);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (end_reg)
                    begin
                        rel.en     = 1'b1;
                        rel.bank   = bank_reg;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            empty_reg <= 1'b0;
            end_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            empty_reg <= empty_next;
            end_reg   <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg  <= bank_next;
        start_reg <= start_next;
        len_reg   <= len_next;
        idx_reg   <= idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && empty_reg) |-> end_reg)
        else $error("empty word not marked as word end");

    a_read_in_bank: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (qwt_pkg::CNT_W'(start_reg) + idx_reg)
                  < qwt_pkg::CNT_W'(qwt_pkg::WORD_DEPTH))
        else $error("buffer read runs past the bank");
`endif

endmodule

// File: rtl/quoted_word_tokenizer.sv
// channel   direction  handshake              word contents
// in        input      in_valid / in_ready    mode, char_in
// out       output     out_valid / out_ready  word_char, char_valid, word_end
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// the front takes one input character per cycle while its buffer bank is free and the word queue has room
// in the back each result character is read from the buffer, then held in the output register
// two buffer banks: input stalls once two words wait to be emitted
// reset is asynchronous active low; no clearing pass, buffer is written before read
// cfg_ready is always high; writes are meant for idle periods only
module quoted_word_tokenizer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        mode,
    input  logic [7:0]                  char_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  word_char,
    output logic                        char_valid,
    output logic                        word_end,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [qwt_pkg::CFG_DW-1:0]  cfg_data
);

    // buffer writes, front to back
    qwt_pkg::wr_t  wr;

    // finished words, front to queue to back
    logic          fq_valid;
    logic          fq_ready;
    qwt_pkg::cmd_t fq_cmd;
    logic          qb_valid;
    logic          qb_ready;
    qwt_pkg::cmd_t qb_cmd;

    // bank handed back once its last result leaves
    qwt_pkg::rel_t rel;

    // splitting, line cap, quote tracking, trim, strip decision and word limit
    qwt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .char_in   (char_in),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .wr        (wr),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (fq_cmd),
        .rel       (rel)
    );

    // short word queue so either side can stall alone
    qwt_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    // word buffer and result walker
    qwt_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .cmd_valid  (qb_valid),
        .cmd_ready  (qb_ready),
        .cmd        (qb_cmd),
        .rel        (rel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .word_char  (word_char),
        .char_valid (char_valid),
        .word_end   (word_end)
    );

endmodule
